// ----- design/pcrl_pkg.sv -----
// Shared constants and types for the palette cycle reverse lookup unit.
package pcrl_pkg;

    localparam int PALETTE_SIZE = 256;
    localparam int IDX_W        = $clog2(PALETTE_SIZE);
    localparam int COLOR_BITS   = 16;
    localparam int SPEED_W      = 8;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam logic [SPEED_W-1:0] SPEED_RESET = SPEED_W'(4);

    // Register index, taken from byte address bits above the word offset
    localparam logic REG_SPEED = 1'b0;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_PIXEL = 1'b1;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_WIN   = 6'b000010,
        S_SCAN  = 6'b000100,
        S_DRAIN = 6'b001000,
        S_FETCH = 6'b010000,
        S_READ  = 6'b100000
    } state_t;

endpackage

// ----- design/pcrl_if.sv -----
// Request and result channel interfaces of the palette cycle reverse lookup unit.
interface pcrl_in_if
    import pcrl_pkg::*;
    ();
    logic                  valid;
    logic                  ready;
    logic                  op;
    logic [IDX_W-1:0]      entry_index;
    logic [COLOR_BITS-1:0] color_in;

    modport source (output valid, output op, output entry_index, output color_in,
                    input ready);
    modport sink   (input valid, input op, input entry_index, input color_in,
                    output ready);
endinterface

interface pcrl_out_if
    import pcrl_pkg::*;
    ();
    logic                  valid;
    logic                  ready;
    logic [COLOR_BITS-1:0] color_out;
    logic                  matched;

    modport source (output valid, output color_out, output matched, input ready);
    modport sink   (input valid, input color_out, input matched, output ready);
endinterface

// ----- design/palette_cycle_reverse_lookup_unit.sv -----
// Top level: palette store, search sequencer and cycled colour output.
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+-------------------------------
//  in_ch    | in  | valid/ready   | op, entry_index, color_in
//  out_ch   | out | valid/ready   | color_out, matched
//  apb      | in  | psel/penable  | speed at byte address 0
//
// A load request is written straight into the palette. A pixel request reads the hint window, up to
// 4*speed+1 entries clipped to the palette, then all 256 entries in the full scan,
// one compare a cycle on the single registered read port of the palette memory,
// then drains, fetches and presents; a hit ends the search early and skips the drain.
// The sequencer returns to idle before the next request is taken.
// Reset clears the hint, speed and the control state; the palette is not cleared.
// in_ch is ready only while idle; a finished result waits in the output
// register and the sequencer holds in its last state until that slot frees.
module palette_cycle_reverse_lookup_unit
    import pcrl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    pcrl_in_if.sink            in_ch,
    pcrl_out_if.source         out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [COLOR_BITS-1:0] mem [PALETTE_SIZE];
    logic [COLOR_BITS-1:0] rd_data_reg;
    logic [IDX_W-1:0]      rd_addr;

    state_t                state_reg;
    logic [SPEED_W-1:0]    speed_reg;
    logic [IDX_W-1:0]      hint_reg;
    logic [IDX_W-1:0]      cursor_reg;
    logic [IDX_W-1:0]      lower_reg;
    logic [IDX_W-1:0]      addr_q_reg;
    logic                  cmp_valid_reg;
    logic [COLOR_BITS-1:0] color_reg;
    logic [IDX_W-1:0]      found_reg;
    logic                  hit_reg;
    logic                  out_valid_reg;
    logic [COLOR_BITS-1:0] color_out_reg;
    logic                  matched_reg;

    logic                  in_fire;
    logic                  cfg_write;
    logic                  cmp_hit;
    logic                  out_free;
    logic [IDX_W+1:0]      upper_sum;
    logic [IDX_W:0]        span;
    logic [IDX_W-1:0]      upper;
    logic [IDX_W-1:0]      lower;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_SPEED) ? PDATA_W'(speed_reg) : '0;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_fire     = in_ch.valid && in_ch.ready;

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.color_out = color_out_reg;
    assign out_ch.matched   = matched_reg;
    assign out_free         = !out_valid_reg || out_ch.ready;

    // Window bounds around the hint, clipped to the palette
    assign span      = {speed_reg, 1'b0};
    assign upper_sum = {2'b00, hint_reg} + {1'b0, span};
    assign upper     = (upper_sum > (IDX_W+2)'(PALETTE_SIZE - 1))
                       ? IDX_W'(PALETTE_SIZE - 1) : upper_sum[IDX_W-1:0];
    assign lower     = ({1'b0, hint_reg} > span)
                       ? IDX_W'({1'b0, hint_reg} - span) : '0;

    assign cmp_hit = cmp_valid_reg && (rd_data_reg == color_reg);

    always_comb
    begin
        if (state_reg == S_WIN || state_reg == S_SCAN)
        begin
            rd_addr = cursor_reg;
        end
        else
        begin
            rd_addr = found_reg + IDX_W'(speed_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && in_ch.op == OP_LOAD)
        begin
            mem[in_ch.entry_index] <= in_ch.color_in;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg <= SPEED_RESET;
        end
        else if (cfg_write && paddr[2] == REG_SPEED)
        begin
            speed_reg <= pwdata[SPEED_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        addr_q_reg <= cursor_reg;
        if (in_fire)
        begin
            color_reg  <= in_ch.color_in;
            cursor_reg <= upper;
            lower_reg  <= lower;
        end
        else if (state_reg == S_WIN)
        begin
            cursor_reg <= (cursor_reg == lower_reg) ? '0 : cursor_reg - 1'b1;
        end
        else if (state_reg == S_SCAN)
        begin
            cursor_reg <= cursor_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            hint_reg      <= '0;
            found_reg     <= '0;
            hit_reg       <= 1'b0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            color_out_reg <= '0;
            matched_reg   <= 1'b0;
        end
        else
        begin
            cmp_valid_reg <= (state_reg == S_WIN || state_reg == S_SCAN) && !cmp_hit;
            // The read state reloads the slot itself when it frees
            if (out_valid_reg && out_ch.ready && state_reg != S_READ)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire && in_ch.op == OP_PIXEL)
                    begin
                        state_reg <= S_WIN;
                    end
                end
                S_WIN, S_SCAN:
                begin
                    if (cmp_hit)
                    begin
                        found_reg <= addr_q_reg;
                        hit_reg   <= 1'b1;
                        state_reg <= S_FETCH;
                    end
                    else if (state_reg == S_WIN && cursor_reg == lower_reg)
                    begin
                        state_reg <= S_SCAN;
                    end
                    else if (state_reg == S_SCAN && cursor_reg == IDX_W'(PALETTE_SIZE - 1))
                    begin
                        state_reg <= S_DRAIN;
                    end
                end
                S_DRAIN:
                begin
                    // Last scan entry is compared here; fall back to index 0 on a miss
                    found_reg <= cmp_hit ? addr_q_reg : '0;
                    hit_reg   <= cmp_hit;
                    state_reg <= S_FETCH;
                end
                S_FETCH:
                begin
                    hint_reg  <= found_reg;
                    state_reg <= S_READ;
                end
                S_READ:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        color_out_reg <= rd_data_reg;
                        matched_reg   <= hit_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_READ))
        else $error("result raised outside the read state");

    a_win_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WIN |=> state_reg == S_WIN || state_reg == S_SCAN
                               || state_reg == S_FETCH)
        else $error("window search left to an illegal state");

    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN && cursor_reg == IDX_W'(PALETTE_SIZE - 1)
        |=> state_reg == S_DRAIN || state_reg == S_FETCH)
        else $error("full scan ran past the last entry");

    a_no_stale_compare: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FETCH |=> !cmp_valid_reg)
        else $error("compare still pending after the search finished");

    a_hint_only_on_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        hint_reg != $past(hint_reg) |-> $past(state_reg == S_FETCH))
        else $error("hint changed outside a fetch");

endmodule

// ----- tb/sv/tb_palette_cycle_reverse_lookup_unit.sv -----
// Self-checking testbench: palette loads and pixel lookups against a local colour-cycling model.
`timescale 1ns / 1ps

module tb_palette_cycle_reverse_lookup_unit;
    import pcrl_pkg::*;

    localparam int DRAIN_CYCLES = 300;
    localparam int NUM_PHASES   = 6;
    localparam int RAND_PER_PHASE = 230;
    localparam logic [PADDR_W-1:0] SPEED_ADDR = PADDR_W'({REG_SPEED, 2'b00});

    typedef struct {
        logic                  op;
        logic [IDX_W-1:0]      slot;
        logic [COLOR_BITS-1:0] colour;
        bit                    fence;
    } pal_req_t;

    typedef struct {
        logic [COLOR_BITS-1:0] color_out;
        logic                  matched;
    } cycled_colour_t;

    logic clk = 1'b0;
    logic rst_n;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    pcrl_in_if  in_ch ();
    pcrl_out_if out_ch ();

    palette_cycle_reverse_lookup_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 clk = ~clk;

    // Model state
    logic [COLOR_BITS-1:0] pal_model [PALETTE_SIZE];
    logic [IDX_W-1:0]      hint_model;
    logic [SPEED_W-1:0]    speed_model;

    // Palette as the generator sees it once every queued request has landed
    logic [COLOR_BITS-1:0] gen_pal [PALETTE_SIZE];

    pal_req_t       pending_req_q [$];
    cycled_colour_t cycled_color_q [$];
    pal_req_t       cur_req;

    bit calm;
    int errors;
    int n_loads, n_pixels, n_found, n_fallback, n_checked;
    logic [SPEED_W-1:0] mid_speed;

    function automatic cycled_colour_t cycled_lookup(input logic [COLOR_BITS-1:0] colour);
        int             span;
        int             upper;
        int             lower;
        int             found;
        bit             hit;
        cycled_colour_t r;
        span  = 2 * int'(speed_model);
        upper = int'(hint_model) + span;
        lower = int'(hint_model) - span;
        if (upper > PALETTE_SIZE - 1)
            upper = PALETTE_SIZE - 1;
        if (lower < 0)
            lower = 0;
        hit   = 1'b0;
        found = 0;
        // downward through the hint window first
        for (int i = upper; i >= lower && !hit; i--)
            if (pal_model[i] == colour)
            begin
                hit   = 1'b1;
                found = i;
            end
        for (int i = 0; i < PALETTE_SIZE && !hit; i++)
            if (pal_model[i] == colour)
            begin
                hit   = 1'b1;
                found = i;
            end
        hint_model  = IDX_W'(found);
        r.color_out = pal_model[(found + int'(speed_model)) % PALETTE_SIZE];
        r.matched   = hit;
        return r;
    endfunction

    function automatic void apply_request(input pal_req_t req);
        cycled_colour_t r;
        if (req.op == OP_LOAD)
        begin
            pal_model[req.slot] = req.colour;
            n_loads++;
        end
        else
        begin
            r = cycled_lookup(req.colour);
            cycled_color_q.push_back(r);
            n_pixels++;
            if (r.matched)
                n_found++;
            else
                n_fallback++;
        end
    endfunction

    // Driver: present requests from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                apply_request(cur_req);
            if (!in_ch.valid || in_ch.ready)
            begin
                if (pending_req_q.size() != 0
                    && !(pending_req_q[0].fence && cycled_color_q.size() != 0)
                    && (calm || $urandom_range(99) >= 24))
                begin
                    cur_req           = pending_req_q.pop_front();
                    in_ch.valid       <= 1'b1;
                    in_ch.op          <= cur_req.op;
                    in_ch.entry_index <= cur_req.slot;
                    in_ch.color_in    <= cur_req.colour;
                end
                else
                begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        cycled_colour_t exp_r;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (cycled_color_q.size() == 0)
                begin
                    $display("%0t: unexpected result color_out %h matched %b", $time,
                             out_ch.color_out, out_ch.matched);
                    errors++;
                end
                else
                begin
                    exp_r = cycled_color_q.pop_front();
                    n_checked++;
                    if (out_ch.color_out !== exp_r.color_out)
                    begin
                        $display("%0t: color_out expected %h actual %h", $time,
                                 exp_r.color_out, out_ch.color_out);
                        errors++;
                    end
                    if (out_ch.matched !== exp_r.matched)
                    begin
                        $display("%0t: matched expected %b actual %b", $time,
                                 exp_r.matched, out_ch.matched);
                        errors++;
                    end
                end
            end
            out_ch.ready <= calm || ($urandom_range(99) >= 24);
        end
    end

    task automatic queue_load(input logic [IDX_W-1:0] slot, input logic [COLOR_BITS-1:0] colour);
        pal_req_t req;
        req.op     = OP_LOAD;
        req.slot   = slot;
        req.colour = colour;
        req.fence  = 1'b0;
        pending_req_q.push_back(req);
        gen_pal[slot] = colour;
    endtask

    task automatic queue_pixel(input logic [COLOR_BITS-1:0] colour, input bit fence);
        pal_req_t req;
        req.op     = OP_PIXEL;
        req.slot   = IDX_W'($urandom);
        req.colour = colour;
        req.fence  = fence;
        pending_req_q.push_back(req);
    endtask

    // A colour held by no palette entry, for the fallback case
    function automatic logic [COLOR_BITS-1:0] absent_colour();
        logic [COLOR_BITS-1:0] c;
        bit                    clash;
        do
        begin
            c     = COLOR_BITS'($urandom);
            clash = 1'b0;
            foreach (gen_pal[i])
                if (gen_pal[i] == c)
                    clash = 1'b1;
        end
        while (clash);
        return c;
    endfunction

    task automatic queue_random(input int count);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 20)
            begin
                // half the loads copy another entry so that duplicates build up
                if ($urandom_range(1))
                    queue_load(IDX_W'($urandom), gen_pal[$urandom_range(PALETTE_SIZE - 1)]);
                else
                    queue_load(IDX_W'($urandom), COLOR_BITS'($urandom));
            end
            else if (pick < 80)
                queue_pixel(gen_pal[$urandom_range(PALETTE_SIZE - 1)], (n % 90) == 45);
            else if (pick < 90)
                queue_pixel($urandom_range(1) ? gen_pal[$urandom_range(7)]
                                              : gen_pal[PALETTE_SIZE - 1 - $urandom_range(7)],
                            1'b0);
            else
                queue_pixel(COLOR_BITS'($urandom), 1'b0);
        end
    endtask

    task automatic drain_all();
        while (pending_req_q.size() != 0 || in_ch.valid || cycled_color_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_speed(input logic [SPEED_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= SPEED_ADDR;
        pwdata  <= PDATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        speed_model = value;
    endtask

    initial
    begin
        logic [SPEED_W-1:0] speeds [NUM_PHASES];
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        in_ch.valid       = 1'b0;
        in_ch.op          = OP_LOAD;
        in_ch.entry_index = '0;
        in_ch.color_in    = '0;
        out_ch.ready      = 1'b0;
        calm              = 1'b0;
        errors            = 0;
        hint_model        = '0;
        speed_model       = SPEED_RESET;
        mid_speed         = SPEED_W'($urandom_range(2, 254));
        speeds            = '{8'd0, 8'd255, 8'd1, 8'd33, mid_speed, 8'd128};
        foreach (pal_model[i])
        begin
            pal_model[i] = '0;
            gen_pal[i]   = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Fill the whole palette before any lookup touches it
        for (int i = 0; i < PALETTE_SIZE; i++)
            queue_load(IDX_W'(i), COLOR_BITS'($urandom));
        queue_load(8'd0, 16'h0000);
        queue_load(8'd1, 16'hAAAA);
        queue_load(8'd254, 16'h5555);
        queue_load(8'd255, 16'hFFFF);

        // Directed lookups at reset speed
        queue_pixel(16'hFFFF, 1'b0);        // found by the full scan at the top entry
        queue_pixel(16'h5555, 1'b0);        // window clipped at the top
        queue_pixel(absent_colour(), 1'b0); // fallback to index 0
        queue_pixel(16'h0000, 1'b0);        // window clipped at the bottom
        queue_load(8'd3, 16'hFFFF);
        queue_load(8'd200, 16'hFFFF);
        queue_pixel(16'hFFFF, 1'b0);        // window hit ahead of the earlier scan hit
        queue_load(8'd8, 16'hFFFF);
        queue_pixel(16'hFFFF, 1'b0);        // downward window finds entry 8 before entry 3
        queue_pixel(16'hFFFF, 1'b1);
        queue_pixel(16'hAAAA, 1'b0);
        queue_load(8'd100, 16'h1234);
        queue_pixel(16'h1234, 1'b0);
        queue_load(8'd92, 16'h1234);
        queue_pixel(16'h1234, 1'b0);        // window finds entry 100 before entry 92 at its lower bound
        queue_pixel(absent_colour(), 1'b0);
        queue_random(RAND_PER_PHASE);
        drain_all();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_speed(speeds[p]);
            // hold both sides busy-free for one whole phase
            calm = (p == 3);
            queue_random(RAND_PER_PHASE - 40);
            drain_all();
        end
        calm = 1'b0;

        if (cycled_color_q.size() != 0)
        begin
            $display("%0t: %0d expected results never arrived", $time, cycled_color_q.size());
            errors++;
        end
        $display("Covered %0d palette loads and %0d pixel lookups (%0d found, %0d fallback)",
                 n_loads, n_pixels, n_found, n_fallback);
        $display("Speeds 4, 0, 255, 1, 33, %0d, 128; %0d results checked, %0d errors",
                 mid_speed, n_checked, errors);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #12_000_000;
        $display("Timeout at %0t", $time);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
